@@ hdl/atodb_pkg.sv @@
package atodb_pkg;

    localparam int TABLE_SIZE_DEF      = 256;
    localparam int INPUT_FRAC_BITS_DEF = 28;
    localparam int MAX_TABLE           = 1024;
    localparam int AMP_SLOT            = 64;
    localparam int DB_SLOT             = 32;
    localparam int IN_W                = 32;
    localparam int LEVEL_W             = 24;
    localparam int DIV_BITS            = 2;
    localparam int ROOT_STEPS          = 30;
    localparam int LOG_FRAC_BITS       = 48;

    localparam longint DB_FIRST_Q16        = -64'sd7864320;
    localparam longint DB_SPAN_Q16         = 64'sd9172493;
    localparam longint LOG2_10_OVER_20_Q32 = 64'sd713378626;

    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_LOW  = 2'd1,
        CLAMP_HIGH = 2'd2
    } t_clamp_code;

    typedef struct packed {
        logic below;
        logic above;
    } t_clamp_flags;

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        logic [63:0] vv;
        int i;
        res = '0;
        b   = 64'd1 << 62;
        vv  = v;
        for (i = 0; i < 32; i++) begin
            if (vv >= res + b) begin
                vv  = vv - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [(ROOT_STEPS+1)*64-1:0] root_rom();
        logic [(ROOT_STEPS+1)*64-1:0] rom;
        int i;
        rom = '0;
        rom[0 +: 64] = 64'd2 << 30;
        for (i = 1; i <= ROOT_STEPS; i++) begin
            rom[i*64 +: 64] = isqrt64(rom[(i-1)*64 +: 64] << 30);
        end
        return rom;
    endfunction

    function automatic logic [63:0] amp_of_db(longint db, int frac,
                                              logic [(ROOT_STEPS+1)*64-1:0] roots);
        longint t;
        logic [63:0] p;
        logic [63:0] f;
        logic [63:0] m;
        int i;
        t = db * LOG2_10_OVER_20_Q32 + (longint'(frac) <<< LOG_FRAC_BITS);
        if (t < 0) begin
            return '0;
        end
        p = 64'(t) >> LOG_FRAC_BITS;
        f = 64'(t) & ((64'd1 << LOG_FRAC_BITS) - 64'd1);
        m = 64'd1 << 30;
        for (i = 1; i <= ROOT_STEPS; i++) begin
            if (f[LOG_FRAC_BITS-i]) begin
                m = (m * roots[i*64 +: 64]) >> 30;
            end
        end
        if (p >= 64'd30) begin
            if (p - 64'd30 > 64'd31) begin
                return '1;
            end
            return m << (p - 64'd30);
        end
        return (m + (64'd1 << (64'd29 - p))) >> (64'd30 - p);
    endfunction

    function automatic logic [MAX_TABLE*DB_SLOT-1:0] db_rom(int table_size,
                                                           longint step, longint rem);
        logic [MAX_TABLE*DB_SLOT-1:0] rom;
        longint db;
        longint acc;
        int k;
        rom = '0;
        db  = DB_FIRST_Q16;
        acc = 0;
        for (k = 0; k < MAX_TABLE; k++) begin
            if (k < table_size) begin
                rom[k*DB_SLOT +: DB_SLOT] = DB_SLOT'(db);
                db  = db + step;
                acc = acc + rem;
                if (acc >= longint'(table_size - 1)) begin
                    acc = acc - longint'(table_size - 1);
                    db  = db + 1;
                end
            end
        end
        return rom;
    endfunction

    function automatic logic [MAX_TABLE*AMP_SLOT-1:0] amp_rom(int table_size, int frac,
                                                             longint step, longint rem);
        logic [MAX_TABLE*AMP_SLOT-1:0] rom;
        logic [(ROOT_STEPS+1)*64-1:0] roots;
        logic [63:0] a;
        logic [63:0] prev;
        longint db;
        longint acc;
        int k;
        rom   = '0;
        roots = root_rom();
        prev  = '0;
        db    = DB_FIRST_Q16;
        acc   = 0;
        for (k = 0; k < MAX_TABLE; k++) begin
            if (k < table_size) begin
                a = amp_of_db(db, frac, roots);
                if (k > 0 && a < prev) begin
                    a = prev;
                end
                rom[k*AMP_SLOT +: AMP_SLOT] = a;
                prev = a;
                db   = db + step;
                acc  = acc + rem;
                if (acc >= longint'(table_size - 1)) begin
                    acc = acc - longint'(table_size - 1);
                    db  = db + 1;
                end
            end
        end
        return rom;
    endfunction

endpackage

@@ hdl/amplitude_to_db_interp.sv @@
// Amplitude to decibel converter (20*log10) over a TABLE_SIZE-point breakpoint ROM, unsigned
// Q4.28 in, signed Q7.16 out. Fully pipelined: one sample per cycle while the output is not
// stalled. The binary segment search takes one stage per table level and the rounding divide
// of the interpolation retires two quotient bits per stage; these two chains set the depth.
// A stall on the output freezes the whole pipe.
// Inputs below the first breakpoint or above the last return the end levels with a clamp
// code of 1 or 2; everything else is interpolated with code 0, and a segment of zero width
// returns its lower level.
module amplitude_to_db_interp #(
    parameter int TABLE_SIZE      = atodb_pkg::TABLE_SIZE_DEF,
    parameter int INPUT_FRAC_BITS = atodb_pkg::INPUT_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [atodb_pkg::IN_W-1:0]          i_amplitude,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [atodb_pkg::LEVEL_W-1:0] o_level_db,
    output logic [1:0]                          o_clamp_code
);
    import atodb_pkg::*;

    localparam int L  = $clog2(TABLE_SIZE);
    localparam int P  = 1 << L;
    localparam int AW = (INPUT_FRAC_BITS + 4 > IN_W) ? INPUT_FRAC_BITS + 4 : IN_W;
    localparam longint DB_STEP = DB_SPAN_Q16 / (TABLE_SIZE - 1);
    localparam longint DB_REM  = DB_SPAN_Q16 % (TABLE_SIZE - 1);
    localparam int QW = $clog2(DB_STEP + 2);
    localparam int NW = QW + AW + 1;
    localparam int ND = (QW + DIV_BITS - 1) / DIV_BITS;

    localparam logic [MAX_TABLE*AMP_SLOT-1:0] AMP_ROM =
        amp_rom(TABLE_SIZE, INPUT_FRAC_BITS, DB_STEP, DB_REM);
    localparam logic [MAX_TABLE*DB_SLOT-1:0] DB_ROM = db_rom(TABLE_SIZE, DB_STEP, DB_REM);

    localparam logic [AW-1:0] AMP_FIRST = AMP_ROM[0 +: AW];
    localparam logic [AW-1:0] AMP_LAST  = AMP_ROM[(TABLE_SIZE-1)*AMP_SLOT +: AW];
    localparam logic signed [LEVEL_W-1:0] DB_FIRST = DB_ROM[0 +: LEVEL_W];
    localparam logic signed [LEVEL_W-1:0] DB_LAST  =
        DB_ROM[(TABLE_SIZE-1)*DB_SLOT +: LEVEL_W];

    localparam int S_N    = L + 4;
    localparam int S_O    = S_N + ND + 1;
    localparam int NSTG   = S_O + 1;

    logic [AW-1:0]              w_amp [P];
    logic signed [LEVEL_W-1:0]  w_db  [P];
    logic [QW-1:0]              w_ddb [P];

    for (genvar k = 0; k < P; k++) begin : g_rom
        if (k >= TABLE_SIZE) begin : g_pad
            assign w_amp[k] = '1;
            assign w_db[k]  = '0;
            assign w_ddb[k] = '0;
        end else begin : g_ent
            localparam logic signed [DB_SLOT-1:0] DBK = DB_ROM[k*DB_SLOT +: DB_SLOT];
            assign w_amp[k] = AMP_ROM[k*AMP_SLOT +: AW];
            assign w_db[k]  = DBK[LEVEL_W-1:0];
            if (k == 0) begin : g_first
                assign w_ddb[k] = '0;
            end else begin : g_rest
                localparam logic signed [DB_SLOT-1:0] DBP =
                    DB_ROM[(k-1)*DB_SLOT +: DB_SLOT];
                localparam logic signed [DB_SLOT-1:0] DIFF = DBK - DBP;
                assign w_ddb[k] = DIFF[QW-1:0];
            end
        end
    end

    logic [NSTG-1:0] r_vld;
    logic            w_en;

    assign o_stall = r_vld[S_O] && i_stall;
    assign w_en    = !o_stall;
    assign o_valid = r_vld[S_O];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // segment search
    logic [IN_W-1:0] r_s_x   [L+1];
    logic [L-1:0]    r_s_pos [L+1];
    t_clamp_flags    r_s_flg [L+1];
    t_clamp_flags    n_flg;

    always_comb begin
        n_flg.below = AW'(i_amplitude) < AMP_FIRST;
        n_flg.above = AW'(i_amplitude) > AMP_LAST;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_x[0]   <= i_amplitude;
            r_s_pos[0] <= '0;
            r_s_flg[0] <= n_flg;
        end
    end

    for (genvar j = 1; j <= L; j++) begin : g_search
        localparam int STEP = 1 << (L - j);
        logic [L-1:0] w_probe;
        logic         w_hit;

        assign w_probe = r_s_pos[j-1] + L'(STEP - 1);
        assign w_hit   = w_amp[w_probe] < AW'(r_s_x[j-1]);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_s_x[j]   <= r_s_x[j-1];
                r_s_flg[j] <= r_s_flg[j-1];
                r_s_pos[j] <= w_hit ? r_s_pos[j-1] + L'(STEP) : r_s_pos[j-1];
            end
        end
    end

    // breakpoint fetch
    logic [L-1:0]              w_c;
    logic [L-1:0]              w_cm1;
    logic [IN_W-1:0]           r_f_x;
    logic [AW-1:0]             r_f_a0;
    logic [AW-1:0]             r_f_a1;
    logic signed [LEVEL_W-1:0] r_f_db0;
    logic [QW-1:0]             r_f_ddb;
    t_clamp_flags              r_f_flg;

    assign w_c   = (r_s_pos[L] == '0) ? L'(1) : r_s_pos[L];
    assign w_cm1 = w_c - L'(1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_x   <= r_s_x[L];
            r_f_a0  <= w_amp[w_cm1];
            r_f_a1  <= w_amp[w_c];
            r_f_db0 <= w_db[w_cm1];
            r_f_ddb <= w_ddb[w_c];
            r_f_flg <= r_s_flg[L];
        end
    end

    // differences
    logic [AW-1:0]             r_d_den;
    logic [AW-1:0]             r_d_dx;
    logic signed [LEVEL_W-1:0] r_d_db0;
    logic [QW-1:0]             r_d_ddb;
    t_clamp_flags              r_d_flg;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_den <= r_f_a1 - r_f_a0;
            r_d_dx  <= AW'(r_f_x) - r_f_a0;
            r_d_db0 <= r_f_db0;
            r_d_ddb <= r_f_ddb;
            r_d_flg <= r_f_flg;
        end
    end

    // product
    logic [QW+AW-1:0]          r_m_prod;
    logic [AW-1:0]             r_m_den;
    logic signed [LEVEL_W-1:0] r_m_db0;
    t_clamp_flags              r_m_flg;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_prod <= {{AW{1'b0}}, r_d_ddb} * {{QW{1'b0}}, r_d_dx};
            r_m_den  <= r_d_den;
            r_m_db0  <= r_d_db0;
            r_m_flg  <= r_d_flg;
        end
    end

    // rounding divide
    logic [NW-1:0]             r_q_rem [ND+1];
    logic [QW-1:0]             r_q_quo [ND+1];
    logic [AW-1:0]             r_q_den [ND+1];
    logic signed [LEVEL_W-1:0] r_q_db0 [ND+1];
    t_clamp_flags              r_q_flg [ND+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q_rem[0] <= {1'b0, r_m_prod} + {{(QW+1){1'b0}}, r_m_den >> 1};
            r_q_quo[0] <= '0;
            r_q_den[0] <= r_m_den;
            r_q_db0[0] <= r_m_db0;
            r_q_flg[0] <= r_m_flg;
        end
    end

    for (genvar s = 0; s < ND; s++) begin : g_div
        logic [NW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        always_comb begin
            n_rem = r_q_rem[s];
            n_quo = r_q_quo[s];
            for (int j = 0; j < DIV_BITS; j++) begin
                if (QW - 1 - s*DIV_BITS - j >= 0) begin
                    if (n_rem >= ({{(QW+1){1'b0}}, r_q_den[s]} << (QW - 1 - s*DIV_BITS - j)))
                    begin
                        n_rem = n_rem -
                            ({{(QW+1){1'b0}}, r_q_den[s]} << (QW - 1 - s*DIV_BITS - j));
                        n_quo[QW - 1 - s*DIV_BITS - j] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_q_rem[s+1] <= n_rem;
                r_q_quo[s+1] <= n_quo;
                r_q_den[s+1] <= r_q_den[s];
                r_q_db0[s+1] <= r_q_db0[s];
                r_q_flg[s+1] <= r_q_flg[s];
            end
        end
    end

    // output
    logic signed [LEVEL_W-1:0] r_o_level;
    t_clamp_code               r_o_code;
    logic signed [LEVEL_W-1:0] n_level;
    t_clamp_code               n_code;

    always_comb begin
        priority if (r_q_flg[ND].below) begin
            n_level = DB_FIRST;
            n_code  = CLAMP_LOW;
        end else if (r_q_flg[ND].above) begin
            n_level = DB_LAST;
            n_code  = CLAMP_HIGH;
        end else if (r_q_den[ND] == '0) begin
            n_level = r_q_db0[ND];
            n_code  = CLAMP_NONE;
        end else begin
            n_level = r_q_db0[ND] + $signed({{(LEVEL_W-QW){1'b0}}, r_q_quo[ND]});
            n_code  = CLAMP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_level <= n_level;
            r_o_code  <= n_code;
        end
    end

    assign o_level_db   = r_o_level;
    assign o_clamp_code = r_o_code;

    a_low_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clamp_code == CLAMP_LOW) |-> (o_level_db == DB_FIRST))
        else $error("clamp below without first level");

    a_high_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clamp_code == CLAMP_HIGH) |-> (o_level_db == DB_LAST))
        else $error("clamp above without last level");

    a_interp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clamp_code == CLAMP_NONE) |->
            (o_level_db >= DB_FIRST && o_level_db <= DB_LAST))
        else $error("interpolated level outside table");

    a_hold_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_level_db) && $stable(o_clamp_code)))
        else $error("stalled request dropped or changed");

endmodule
